// ----- src/rbpb_pkg.sv -----
// Shared constants, codes and sine/cosine table functions for the rotated bitmap blit.
`timescale 1ns / 1ps
`default_nettype none

package rbpb_pkg;

   localparam int SCREEN_SIZE_DEF   = 200;
   localparam int STORE_BYTES_DEF   = 2048;
   localparam int ANGLE_ENTRIES_DEF = 512;

   localparam int ADDR_W   = 11;
   localparam int BYTE_W   = 8;
   localparam int PIX_W    = 8;
   localparam int ANGLE_W  = 9;
   localparam int COLOR_W  = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Linear byte address before the store wrap, and the compare width for the wrap.
   localparam int LIN_W = 13;
   localparam int WRAP_CMP_W = 18;
   // Wide enough to compare an 8-bit coordinate or 9-bit angle with default parameters.
   localparam int LIMIT_W = 11;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_QUERY = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_ROT_ANGLE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BMP_WIDTH  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BMP_HEIGHT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_INK_COLOR  = 3'd5;

   localparam logic [ANGLE_W-1:0] ROT_ANGLE_RESET  = 9'd0;
   localparam logic [PIX_W-1:0]   CENTER_RESET     = 8'd100;
   localparam logic [PIX_W-1:0]   BMP_SIZE_RESET   = 8'd8;
   localparam logic [COLOR_W-1:0] INK_COLOR_RESET  = 16'h0000;
   localparam logic [COLOR_W-1:0] INK_DITHER       = 16'hFFFF;
   localparam logic [COLOR_W-1:0] COLOR_BLACK      = 16'h0000;
   localparam logic [COLOR_W-1:0] COLOR_WHITE      = 16'hFFFF;

   localparam int TRIG_W = 16;

   localparam logic [63:0] Q30_ONE     = 64'd1073741824;
   localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
   localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;

   localparam logic [63:0] SIN_DIV [1:12] = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156,
                                            64'd210, 64'd272, 64'd342, 64'd420, 64'd506,
                                            64'd600};
   localparam logic [63:0] COS_DIV [1:12] = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132,
                                            64'd182, 64'd240, 64'd306, 64'd380, 64'd462,
                                            64'd552};

   // Truncating Taylor series of sin or cos over one quadrant, Q30.
   function automatic longint series_q30(input logic [63:0] r, input bit odd);
      logic [63:0] r2;
      logic [63:0] term;
      longint sum;
      r2   = (r * r) >> 30;
      term = odd ? r : Q30_ONE;
      sum  = longint'(term);
      for (int n = 1; n <= 12; n++) begin
         if (odd) begin
            term = ((term * r2) >> 30) / SIN_DIV[n];
         end else begin
            term = ((term * r2) >> 30) / COS_DIV[n];
         end
         if ((n % 2) == 1) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      return sum;
   endfunction

   function automatic logic signed [TRIG_W-1:0] q30_to_q14(input longint v);
      logic [63:0] mag;
      logic [63:0] q;
      mag = (v < 0) ? 64'(-v) : 64'(v);
      q   = (mag + 64'd32768) >> 16;
      return (v < 0) ? -TRIG_W'(q) : TRIG_W'(q);
   endfunction

   // Q1.14 sine or cosine of table entry d, one entry per degree.
   function automatic logic signed [TRIG_W-1:0] trig_q14(input int unsigned d,
                                                       input bit want_sin);
      logic [63:0] theta;
      logic [63:0] t;
      logic [63:0] quad;
      logic [63:0] r;
      longint s0;
      longint c0;
      longint s;
      longint c;
      theta = ((64'(d) * 64'd31415) << 30) / 64'd1800000;
      t     = theta % Q30_TWO_PI;
      quad  = t / Q30_HALF_PI;
      if (quad > 64'd3) begin
         quad = 64'd3;
      end
      r  = t - quad * Q30_HALF_PI;
      s0 = series_q30(r, 1'b1);
      c0 = series_q30(r, 1'b0);
      case (quad)
         64'd0: begin s = s0;  c = c0;  end
         64'd1: begin s = c0;  c = -s0; end
         64'd2: begin s = -s0; c = -c0; end
         default: begin s = -c0; c = s0; end
      endcase
      return want_sin ? q30_to_q14(s) : q30_to_q14(c);
   endfunction

endpackage

`default_nettype wire

// ----- src/rbpb_req_if.sv -----
// Request channel: load one bitmap byte or query one screen pixel.
`timescale 1ns / 1ps
`default_nettype none

interface rbpb_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [rbpb_pkg::ADDR_W-1:0]   byte_addr;
   logic [rbpb_pkg::BYTE_W-1:0]   byte_data;
   logic [rbpb_pkg::PIX_W-1:0]    pix_x;
   logic [rbpb_pkg::PIX_W-1:0]    pix_y;

   modport source (output valid, func, byte_addr, byte_data, pix_x, pix_y, input ready);
   modport sink   (input valid, func, byte_addr, byte_data, pix_x, pix_y, output ready);
endinterface

`default_nettype wire

// ----- src/rbpb_rsp_if.sv -----
// Response channel: one painted or unpainted screen pixel.
`timescale 1ns / 1ps
`default_nettype none

interface rbpb_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [rbpb_pkg::PIX_W-1:0]    out_x;
   logic [rbpb_pkg::PIX_W-1:0]    out_y;
   logic                          draw;
   logic [rbpb_pkg::COLOR_W-1:0]  color;

   modport source (output valid, out_x, out_y, draw, color, input ready);
   modport sink   (input valid, out_x, out_y, draw, color, output ready);
endinterface

`default_nettype wire

// ----- src/rbpb_addr_mod.sv -----
// Two-stage wrap of a linear byte address onto the store depth by reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none

module rbpb_addr_mod #(
   parameter int STORE_BYTES = rbpb_pkg::STORE_BYTES_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            adv,
   input  wire logic [rbpb_pkg::LIN_W-1:0]      lin_addr,
   output      logic [$clog2(STORE_BYTES)-1:0]  mem_addr
);

   localparam int AW          = $clog2(STORE_BYTES);
   localparam int LW          = rbpb_pkg::LIN_W;
   localparam int CW          = rbpb_pkg::WRAP_CMP_W;
   localparam int RecipShift  = LW + 17;
   localparam longint unsigned RECIP = (64'd1 << RecipShift) / STORE_BYTES;
   localparam int RW          = $clog2(RECIP + 1);
   localparam int PW          = LW + RW;
   localparam int QW          = LW + CW;

   logic [LW-1:0] lin_ff;
   logic [LW-1:0] quot_ff;
   logic [LW-1:0] quot_in;
   logic [PW-1:0] recip_prod;
   logic [QW-1:0] back_prod;
   logic [LW-1:0] rem;
   logic [CW-1:0] rem_fix;
   logic [AW-1:0] mem_addr_ff;
   logic [AW-1:0] mem_addr_in;

   // The quotient estimate is the true quotient or one less, so one correction suffices.
   always_comb begin
      recip_prod = PW'(lin_addr) * PW'(RECIP);
      quot_in    = LW'(recip_prod >> RecipShift);
      back_prod  = QW'(quot_ff) * QW'(STORE_BYTES);
      rem        = lin_ff - LW'(back_prod);
      rem_fix    = (CW'(rem) >= CW'(STORE_BYTES)) ? CW'(rem) - CW'(STORE_BYTES) : CW'(rem);
      mem_addr_in = AW'(rem_fix);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lin_ff      <= lin_addr;
         quot_ff     <= quot_in;
         mem_addr_ff <= mem_addr_in;
      end
   end

   assign mem_addr = mem_addr_ff;

endmodule

`default_nettype wire

// ----- src/rotated_bitmap_pixel_blit_top.sv -----
// Top level of the rotated 1-bit bitmap blit: pixel pipeline, bitmap store and registers.
//
//   Channel | Direction | Carries
//   --------+-----------+--------------------------------------------------------
//   req_    | in        | func, byte_addr, byte_data, pix_x, pix_y (valid/ready)
//   rsp_    | out       | out_x, out_y, draw, color (valid/ready)
//   csr_    | in        | we, index, wdata (write only)
//
// One request enters per cycle unless halted; stage seven feeds the registered response.
// The rate is set by the single port of the bitmap store, used by loads and queries in order.
// The pipeline halts only while a finished response waits and the output register is full.
// Reset is synchronous and clears valid bits and control registers, not the bitmap store.
`timescale 1ns / 1ps
`default_nettype none

module rotated_bitmap_pixel_blit_top #(
   parameter int SCREEN_SIZE   = rbpb_pkg::SCREEN_SIZE_DEF,
   parameter int STORE_BYTES   = rbpb_pkg::STORE_BYTES_DEF,
   parameter int ANGLE_ENTRIES = rbpb_pkg::ANGLE_ENTRIES_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   rbpb_req_if.sink                                req_chan,
   rbpb_rsp_if.source                              rsp_chan,
   input  wire logic                               csr_we,
   input  wire logic [rbpb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [rbpb_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   localparam int AW  = $clog2(STORE_BYTES);
   localparam int AIW = $clog2(ANGLE_ENTRIES);
   localparam int LMW = rbpb_pkg::LIMIT_W;
   localparam int TW  = rbpb_pkg::TRIG_W;
   localparam int LW  = rbpb_pkg::LIN_W;
   localparam int PW  = rbpb_pkg::PIX_W;

   typedef struct packed {
      logic                          func;
      logic                          on_screen;
      logic                          in_box;
      logic [2:0]                    bit_sel;
      logic [rbpb_pkg::ADDR_W-1:0]   byte_addr;
      logic [rbpb_pkg::BYTE_W-1:0]   byte_data;
      logic [PW-1:0]                 pix_x;
      logic [PW-1:0]                 pix_y;
   } ctx_type;

   logic [rbpb_pkg::ANGLE_W-1:0]  rot_angle_ff;
   logic [PW-1:0]                 center_x_ff;
   logic [PW-1:0]                 center_y_ff;
   logic [PW-1:0]                 bmp_width_ff;
   logic [PW-1:0]                 bmp_height_ff;
   logic [rbpb_pkg::COLOR_W-1:0]  ink_color_ff;

   logic signed [TW-1:0] cos_tab [ANGLE_ENTRIES];
   logic signed [TW-1:0] sin_tab [ANGLE_ENTRIES];

   for (genvar gi = 0; gi < ANGLE_ENTRIES; gi++) begin : g_trig
      localparam logic signed [TW-1:0] CosV = rbpb_pkg::trig_q14(gi, 1'b0);
      localparam logic signed [TW-1:0] SinV = rbpb_pkg::trig_q14(gi, 1'b1);
      assign cos_tab[gi] = CosV;
      assign sin_tab[gi] = SinV;
   end

   logic adv;
   logic accept;

   logic s1_vld_ff, s2_vld_ff, s3_vld_ff, s4_vld_ff, s5_vld_ff, s6_vld_ff, s7_vld_ff;
   ctx_type s1_ctx_ff, s2_ctx_ff, s3_ctx_ff, s4_ctx_ff, s5_ctx_ff, s6_ctx_ff, s7_ctx_ff;
   ctx_type s1_ctx_in, s4_ctx_in;

   logic [LMW-1:0]          angle_wide;
   logic [AIW-1:0]          angle_idx;
   logic signed [8:0]       s1_dx_ff, s1_dy_ff, s1_dx_in, s1_dy_in;
   logic signed [TW-1:0]    s1_cos_ff, s1_sin_ff;

   logic signed [24:0]      s2_xc_ff, s2_ys_ff, s2_yc_ff, s2_xs_ff;

   logic signed [25:0]      sum_x, sum_y, bias_x, bias_y, adj_x, adj_y;
   logic signed [11:0]      s3_jx_ff, s3_jy_ff;

   logic [PW-1:0]           half_w;
   logic signed [11:0]      src_x, src_y;
   logic [5:0]              row_bytes;
   logic [13:0]             row_lin;
   logic [LW-1:0]           s4_lin_ff, s4_lin_in;

   logic [AW-1:0]           s6_addr;
   logic [rbpb_pkg::BYTE_W-1:0] bitmap_mem [STORE_BYTES];
   logic [rbpb_pkg::BYTE_W-1:0] s7_rd_ff;

   logic                    s7_result;
   logic                    src_bit;
   logic                    draw_in;
   logic [rbpb_pkg::COLOR_W-1:0] color_in;

   logic                    rsp_vld_ff, rsp_vld_in;
   logic [PW-1:0]           rsp_x_ff, rsp_y_ff;
   logic                    rsp_draw_ff;
   logic [rbpb_pkg::COLOR_W-1:0] rsp_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_angle_ff  <= rbpb_pkg::ROT_ANGLE_RESET;
         center_x_ff   <= rbpb_pkg::CENTER_RESET;
         center_y_ff   <= rbpb_pkg::CENTER_RESET;
         bmp_width_ff  <= rbpb_pkg::BMP_SIZE_RESET;
         bmp_height_ff <= rbpb_pkg::BMP_SIZE_RESET;
         ink_color_ff  <= rbpb_pkg::INK_COLOR_RESET;
      end else if (csr_we) begin
         case (csr_index)
            rbpb_pkg::CSR_ROT_ANGLE:  rot_angle_ff  <= csr_wdata[rbpb_pkg::ANGLE_W-1:0];
            rbpb_pkg::CSR_CENTER_X:   center_x_ff   <= csr_wdata[PW-1:0];
            rbpb_pkg::CSR_CENTER_Y:   center_y_ff   <= csr_wdata[PW-1:0];
            rbpb_pkg::CSR_BMP_WIDTH:  bmp_width_ff  <= csr_wdata[PW-1:0];
            rbpb_pkg::CSR_BMP_HEIGHT: bmp_height_ff <= csr_wdata[PW-1:0];
            rbpb_pkg::CSR_INK_COLOR:  ink_color_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The whole pipeline moves together unless a finished response cannot leave stage seven.
   assign s7_result = s7_vld_ff && (s7_ctx_ff.func == rbpb_pkg::FUNC_QUERY)
                      && s7_ctx_ff.on_screen;
   assign adv       = !(s7_result && rsp_vld_ff && !rsp_chan.ready);
   assign accept    = req_chan.valid && req_chan.ready;
   assign req_chan.ready = adv && !reset;

   always_comb begin
      angle_wide = LMW'(rot_angle_ff);
      angle_idx  = (angle_wide >= LMW'(ANGLE_ENTRIES)) ? AIW'(angle_wide - LMW'(ANGLE_ENTRIES))
                                                      : AIW'(angle_wide);
      s1_dx_in = signed'({1'b0, req_chan.pix_x}) - signed'({1'b0, center_x_ff});
      s1_dy_in = signed'({1'b0, req_chan.pix_y}) - signed'({1'b0, center_y_ff});
      s1_ctx_in.func      = req_chan.func;
      s1_ctx_in.on_screen = (LMW'(req_chan.pix_x) < LMW'(SCREEN_SIZE))
                            && (LMW'(req_chan.pix_y) < LMW'(SCREEN_SIZE));
      s1_ctx_in.in_box    = 1'b0;
      s1_ctx_in.bit_sel   = 3'd0;
      s1_ctx_in.byte_addr = req_chan.byte_addr;
      s1_ctx_in.byte_data = req_chan.byte_data;
      s1_ctx_in.pix_x     = req_chan.pix_x;
      s1_ctx_in.pix_y     = req_chan.pix_y;
   end

   // Rotated offsets, truncated toward zero after the Q14 scale.
   always_comb begin
      sum_x  = 26'(s2_xc_ff) + 26'(s2_ys_ff);
      sum_y  = 26'(s2_yc_ff) - 26'(s2_xs_ff);
      bias_x = sum_x[25] ? 26'sd16383 : 26'sd0;
      bias_y = sum_y[25] ? 26'sd16383 : 26'sd0;
      adj_x  = sum_x + bias_x;
      adj_y  = sum_y + bias_y;
   end

   always_comb begin
      half_w    = {1'b0, bmp_width_ff[PW-1:1]};
      src_x     = s3_jx_ff + signed'({4'b0, half_w});
      src_y     = s3_jy_ff + signed'({4'b0, bmp_height_ff});
      row_bytes = 6'((9'(bmp_width_ff) + 9'd7) >> 3);
      row_lin   = 14'(src_y[7:0]) * 14'(row_bytes) + 14'(src_x[7:3]);
      s4_ctx_in = s3_ctx_ff;
      s4_ctx_in.in_box  = !src_x[11] && (src_x < signed'({4'b0, bmp_width_ff}))
                          && !src_y[11] && (src_y < signed'({4'b0, bmp_height_ff}));
      s4_ctx_in.bit_sel = src_x[2:0];
      s4_lin_in = (s3_ctx_ff.func == rbpb_pkg::FUNC_LOAD) ? LW'(s3_ctx_ff.byte_addr)
                                                          : LW'(row_lin);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
         s4_vld_ff <= 1'b0;
         s5_vld_ff <= 1'b0;
         s6_vld_ff <= 1'b0;
         s7_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= accept;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         s4_vld_ff <= s3_vld_ff;
         s5_vld_ff <= s4_vld_ff;
         s6_vld_ff <= s5_vld_ff;
         s7_vld_ff <= s6_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ctx_ff <= s1_ctx_in;
         s1_dx_ff  <= s1_dx_in;
         s1_dy_ff  <= s1_dy_in;
         s1_cos_ff <= cos_tab[angle_idx];
         s1_sin_ff <= sin_tab[angle_idx];

         s2_ctx_ff <= s1_ctx_ff;
         s2_xc_ff  <= 25'(s1_dx_ff) * 25'(s1_cos_ff);
         s2_ys_ff  <= 25'(s1_dy_ff) * 25'(s1_sin_ff);
         s2_yc_ff  <= 25'(s1_dy_ff) * 25'(s1_cos_ff);
         s2_xs_ff  <= 25'(s1_dx_ff) * 25'(s1_sin_ff);

         s3_ctx_ff <= s2_ctx_ff;
         s3_jx_ff  <= adj_x[25:14];
         s3_jy_ff  <= adj_y[25:14];

         s4_ctx_ff <= s4_ctx_in;
         s4_lin_ff <= s4_lin_in;

         s5_ctx_ff <= s4_ctx_ff;
         s6_ctx_ff <= s5_ctx_ff;
         s7_ctx_ff <= s6_ctx_ff;
      end
   end

   rbpb_addr_mod #(
      .STORE_BYTES (STORE_BYTES)
   ) u_addr_mod (
      .clock    (clock),
      .adv      (adv),
      .lin_addr (s4_lin_ff),
      .mem_addr (s6_addr)
   );

   // Loads and queries reach the store in request order at the same stage.
   always_ff @(posedge clock) begin
      if (adv) begin
         if (s6_vld_ff && (s6_ctx_ff.func == rbpb_pkg::FUNC_LOAD)) begin
            bitmap_mem[s6_addr] <= s6_ctx_ff.byte_data;
         end
         s7_rd_ff <= bitmap_mem[s6_addr];
      end
   end

   always_comb begin
      src_bit = s7_rd_ff[3'd7 - s7_ctx_ff.bit_sel];
      draw_in = s7_ctx_ff.in_box && !src_bit;
      if (!draw_in) begin
         color_in = rbpb_pkg::COLOR_BLACK;
      end else if (ink_color_ff == rbpb_pkg::INK_DITHER) begin
         color_in = (s7_ctx_ff.pix_x[0] ^ s7_ctx_ff.pix_y[0]) ? rbpb_pkg::COLOR_WHITE
                                                               : rbpb_pkg::COLOR_BLACK;
      end else begin
         color_in = ink_color_ff;
      end
      rsp_vld_in = (s7_result && adv) || (rsp_vld_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s7_result && adv) begin
         rsp_x_ff     <= s7_ctx_ff.pix_x;
         rsp_y_ff     <= s7_ctx_ff.pix_y;
         rsp_draw_ff  <= draw_in;
         rsp_color_ff <= color_in;
      end
   end

   assign rsp_chan.valid = rsp_vld_ff;
   assign rsp_chan.out_x = rsp_x_ff;
   assign rsp_chan.out_y = rsp_y_ff;
   assign rsp_chan.draw  = rsp_draw_ff;
   assign rsp_chan.color = rsp_color_ff;

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_vld_ff && !s1_vld_ff && !s7_vld_ff)
      else $error("Valid state survived reset.");

   a_addr_in_range: assert property (@(posedge clock) disable iff (reset)
      s6_vld_ff |-> ((AW+1)'(s6_addr) < (AW+1)'(STORE_BYTES)))
      else $error("Wrapped store address is beyond the store depth.");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(s7_vld_ff) && $stable(s7_ctx_ff) && (s7_rd_ff === $past(s7_rd_ff)))
      else $error("Final stage changed while the pipeline was stalled.");

   a_rsp_from_query: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_vld_ff) |-> $past(s7_result))
      else $error("Response raised without an on-screen query in the final stage.");

endmodule

`default_nettype wire
